FILE: hw/rtl/texture_pool_sampler_defines.svh
// Assertion macros shared by the texture pool sampler RTL.
`ifndef TEXTURE_POOL_SAMPLER_DEFINES_SVH
`define TEXTURE_POOL_SAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tps_pkg.sv
// Shared constants of the texture pool sampler: operation and status codes, defaults.
package tps_pkg;

  localparam int unsigned TEXTURE_SLOTS_DEF    = 16;
  localparam int unsigned POOL_TEXELS_DEF      = 32768;
  localparam int unsigned UV_FRACTION_BITS_DEF = 12;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;
  localparam logic [1:0] OP_RESET  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SLOT = 3'd1;
  localparam logic [2:0] ST_NO_SPACE = 3'd2;
  localparam logic [2:0] ST_UNUSED   = 3'd3;
  localparam logic [2:0] ST_OUTSIDE  = 3'd4;

endpackage

FILE: hw/rtl/tps_uv_wrap.sv
// Texture coordinate scaler: fixed-point coordinate times size, floor, repeat-wrap mask.
module tps_uv_wrap #(
  parameter int unsigned FRAC_BITS = tps_pkg::UV_FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] coord_i,
  input  logic        [7:0]  size_i,
  output logic        [7:0]  wrap_o
);

  logic signed [40:0] prod;
  logic        [7:0]  slice_q;
  logic        [7:0]  mask_q;

  assign prod = 41'(coord_i) * 41'($signed({1'b0, size_i}));

  // Only the low eight bits of the floored product survive the mask.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      slice_q <= prod[FRAC_BITS +: 8];
      mask_q  <= size_i - 8'd1;
    end
  end

  assign wrap_o = slice_q & mask_q;

endmodule

FILE: hw/rtl/texture_pool_sampler.sv
// Texture pool sampler top level: slot table, bump allocator and shared pixel memory.
//
// Usage: drive the operation word and raise start_i; it is taken at a rising
// edge where start_i is high and busy_o is low. Operations are create,
// set pixel, sample and reset pool. Each word gives exactly one result,
// shown for one cycle with result_valid_o high; the receiver cannot stall,
// so it must take the result in that cycle.
// Each word runs through its own states: reset pool, bad slot and unused
// slot end in LOOK; create ends in CALC, set pixel in ADDR, and sample passes
// LOOK, CALC, ADDR and, inside the pool, READ. The result cycle is an idle
// cycle, so the next word can be taken while the result shows; the sequencer handles one word at a time.
// The path is set by the registered slot table read, the multiply for the
// row offset (twice for a sample: scaling, then row), and the registered
// pixel memory read.
// Reset clears the in-use bits of all slots and the allocation count at
// once; pixel memory keeps its contents and needs no clearing pass.
// used_bytes_o reports twice the allocated texel count after the operation.
module texture_pool_sampler #(
  parameter int unsigned TEXTURE_SLOTS    = tps_pkg::TEXTURE_SLOTS_DEF,
  parameter int unsigned POOL_TEXELS      = tps_pkg::POOL_TEXELS_DEF,
  parameter int unsigned UV_FRACTION_BITS = tps_pkg::UV_FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic        [1:0]  operation_i,
  input  logic        [7:0]  slot_index_i,
  input  logic        [7:0]  tex_width_i,
  input  logic        [7:0]  tex_height_i,
  input  logic        [7:0]  texel_x_i,
  input  logic        [7:0]  texel_y_i,
  input  logic        [15:0] color_in_i,
  input  logic signed [31:0] coord_u_i,
  input  logic signed [31:0] coord_v_i,
  output logic               result_valid_o,
  output logic        [2:0]  status_o,
  output logic        [7:0]  slot_result_o,
  output logic        [15:0] texel_out_o,
  output logic        [16:0] used_bytes_o
);

  `include "texture_pool_sampler_defines.svh"

  localparam int unsigned SLOT_AW = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
  localparam int unsigned ADDR_W  = $clog2(POOL_TEXELS);
  localparam int unsigned ALLOC_W = $clog2(POOL_TEXELS + 1);
  localparam int unsigned ENT_W   = 16 + ADDR_W;
  localparam int unsigned SUM_W   = ((ADDR_W > 16) ? ADDR_W : 16) + 2;
  localparam int unsigned CMP_W   = (ALLOC_W > 16) ? ALLOC_W : 16;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_CALC = 5'b00100,
    S_ADDR = 5'b01000,
    S_READ = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Latched operation word
  logic        [1:0]  op_q;
  logic        [7:0]  slot_q;
  logic        [7:0]  w_q, h_q, x_q, y_q;
  logic        [15:0] color_q;
  logic signed [31:0] u_q, v_q;

  // Working registers
  logic [7:0]        sw_q;
  logic [ADDR_W-1:0] base_q;
  logic [15:0]       needed_q;
  logic [15:0]       row_q;
  logic [7:0]        col_q;

  // Result registers
  logic        valid_q, valid_d;
  logic [2:0]  status_q, status_d;
  logic [7:0]  slot_res_q, slot_res_d;
  logic [15:0] texel_q, texel_d;

  // Allocation and slot state
  logic [ALLOC_W-1:0]       alloc_q, alloc_d;
  logic [TEXTURE_SLOTS-1:0] slot_used_q, slot_used_d;

  // Memories
  logic [ENT_W-1:0] slot_mem [TEXTURE_SLOTS];
  logic [ENT_W-1:0] slot_rd_q;
  logic [15:0]      pix_mem [POOL_TEXELS];
  logic [15:0]      pix_rd_q;

  logic               accept;
  logic [SLOT_AW-1:0] slot_idx;
  logic               slot_ok;
  logic [7:0]         ent_w, ent_h;
  logic [ADDR_W-1:0]  ent_base;
  logic [7:0]         wrap_u, wrap_v;
  logic [SUM_W-1:0]   addr_sum;
  logic               in_pool;
  logic [ADDR_W-1:0]  pix_addr;
  logic [CMP_W-1:0]   remaining;
  logic               no_space;
  logic               slot_we, pix_we, pix_re;
  logic [ALLOC_W:0]   alloc_dbl;

  assign accept   = start_i && (state_q == S_IDLE);
  assign slot_idx = slot_q[SLOT_AW-1:0];
  assign slot_ok  = {1'b0, slot_q} < 9'(TEXTURE_SLOTS);

  assign ent_w    = slot_rd_q[ENT_W-1 -: 8];
  assign ent_h    = slot_rd_q[ENT_W-9 -: 8];
  assign ent_base = slot_rd_q[ADDR_W-1:0];

  assign addr_sum = SUM_W'(base_q) + SUM_W'(row_q) + SUM_W'(col_q);
  assign in_pool  = addr_sum < SUM_W'(POOL_TEXELS);
  assign pix_addr = addr_sum[ADDR_W-1:0];

  assign remaining = CMP_W'(POOL_TEXELS) - CMP_W'(alloc_q);
  assign no_space  = (needed_q == 16'd0) || (CMP_W'(needed_q) > remaining);

  tps_uv_wrap #(
    .FRAC_BITS(UV_FRACTION_BITS)
  ) u_wrap_u (
    .clk_i  (clk_i),
    .en_i   (state_q == S_LOOK),
    .coord_i(u_q),
    .size_i (ent_w),
    .wrap_o (wrap_u)
  );

  tps_uv_wrap #(
    .FRAC_BITS(UV_FRACTION_BITS)
  ) u_wrap_v (
    .clk_i  (clk_i),
    .en_i   (state_q == S_LOOK),
    .coord_i(v_q),
    .size_i (ent_h),
    .wrap_o (wrap_v)
  );

  always_comb begin
    state_d     = state_q;
    valid_d     = 1'b0;
    status_d    = status_q;
    slot_res_d  = slot_res_q;
    texel_d     = texel_q;
    alloc_d     = alloc_q;
    slot_used_d = slot_used_q;
    slot_we     = 1'b0;
    pix_we      = 1'b0;
    pix_re      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        status_d   = tps_pkg::ST_OK;
        slot_res_d = 8'd0;
        texel_d    = 16'd0;
        if (op_q == tps_pkg::OP_RESET) begin
          slot_used_d = '0;
          alloc_d     = '0;
          valid_d     = 1'b1;
          state_d     = S_IDLE;
        end else if (!slot_ok) begin
          status_d = tps_pkg::ST_BAD_SLOT;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end else if (op_q == tps_pkg::OP_CREATE) begin
          state_d = S_CALC;
        end else if (!slot_used_q[slot_idx]) begin
          status_d = tps_pkg::ST_UNUSED;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end else if (op_q == tps_pkg::OP_SET) begin
          state_d = S_ADDR;
        end else begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        if (op_q == tps_pkg::OP_CREATE) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
          if (no_space) begin
            status_d = tps_pkg::ST_NO_SPACE;
          end else begin
            // A slot already in use is simply overwritten; its old space stays taken.
            slot_we               = 1'b1;
            slot_used_d[slot_idx] = 1'b1;
            alloc_d               = alloc_q + ALLOC_W'(needed_q);
            slot_res_d            = slot_q;
          end
        end else begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        if (op_q == tps_pkg::OP_SET) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
          if (in_pool) begin
            pix_we = 1'b1;
          end else begin
            status_d = tps_pkg::ST_OUTSIDE;
          end
        end else if (in_pool) begin
          pix_re  = 1'b1;
          state_d = S_READ;
        end else begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        texel_d = pix_rd_q;
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= 1'b0;
      alloc_q     <= '0;
      slot_used_q <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      alloc_q     <= alloc_d;
      slot_used_q <= slot_used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    slot_res_q <= slot_res_d;
    texel_q    <= texel_d;
    if (accept) begin
      op_q    <= operation_i;
      slot_q  <= slot_index_i;
      w_q     <= tex_width_i;
      h_q     <= tex_height_i;
      x_q     <= texel_x_i;
      y_q     <= texel_y_i;
      color_q <= color_in_i;
      u_q     <= coord_u_i;
      v_q     <= coord_v_i;
    end
    if (state_q == S_LOOK) begin
      sw_q     <= ent_w;
      base_q   <= ent_base;
      needed_q <= 16'(w_q) * 16'(h_q);
      row_q    <= 16'(y_q) * 16'(ent_w);
      col_q    <= x_q;
    end
    // Sample: take the wrapped column and form the row offset from the wrapped row.
    if (state_q == S_CALC) begin
      col_q <= wrap_u;
      row_q <= 16'(wrap_v) * 16'(sw_q);
    end
  end

  // Slot table: read on accept, written back by a successful create.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_rd_q <= slot_mem[slot_index_i[SLOT_AW-1:0]];
    end
    if (slot_we) begin
      slot_mem[slot_idx] <= {w_q, h_q, alloc_q[ADDR_W-1:0]};
    end
  end

  // Pixel memory: at most one access per word, in the address state.
  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      pix_mem[pix_addr] <= color_q;
    end
    if (pix_re) begin
      pix_rd_q <= pix_mem[pix_addr];
    end
  end

  assign alloc_dbl = {alloc_q, 1'b0};

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign slot_result_o  = slot_res_q;
  assign texel_out_o    = texel_q;
  assign used_bytes_o   = 17'(alloc_dbl);

  `TPS_ASSERT_IMPL(a_result_when_idle, result_valid_o, !busy_o, "result shown while busy")
  `TPS_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted word did not start")
  `TPS_ASSERT_IMPL(a_slot_res_ok, result_valid_o && (slot_result_o != 8'd0),
                   status_o == tps_pkg::ST_OK, "slot result without success")
  `TPS_ASSERT_IMPL(a_write_in_pool, pix_we, in_pool, "pixel write outside pool")
  `TPS_ASSERT_NEXT(a_create_result, slot_we,
                   result_valid_o && (status_o == tps_pkg::ST_OK) && slot_used_q[slot_idx],
                   "create did not complete")
  `TPS_ASSERT_IMPL(a_alloc_bound, 1'b1, alloc_q <= ALLOC_W'(POOL_TEXELS),
                   "allocation beyond pool")

endmodule

FILE: verif/tb_texture_pool_sampler.sv
// Testbench for texture_pool_sampler: directed and random words checked against a predictor.
`timescale 1ns / 1ps

typedef struct {
  logic        [1:0]  op;
  logic        [7:0]  slot;
  logic        [7:0]  w;
  logic        [7:0]  h;
  logic        [7:0]  x;
  logic        [7:0]  y;
  logic        [15:0] color;
  logic signed [31:0] u;
  logic signed [31:0] v;
} tex_word_t;

typedef struct {
  logic [2:0]  status;
  logic [7:0]  slot_res;
  logic [15:0] texel;
  logic [16:0] used;
} tex_result_t;

// Mirror of the slot table, the allocator and the pixel memory, plus the results still due.
class tex_pool_tracker;
  bit [15:0]   texel_mem     [tps_pkg::POOL_TEXELS_DEF];
  bit          texel_written [tps_pkg::POOL_TEXELS_DEF];
  bit [7:0]    slot_w        [tps_pkg::TEXTURE_SLOTS_DEF];
  bit [7:0]    slot_h        [tps_pkg::TEXTURE_SLOTS_DEF];
  int unsigned slot_base     [tps_pkg::TEXTURE_SLOTS_DEF];
  bit          slot_live     [tps_pkg::TEXTURE_SLOTS_DEF];
  int unsigned texels_taken;
  tex_result_t due_results [$];
  int          errors;

  function new();
    clear_slots();
    errors = 0;
  endfunction

  // Pixels survive a pool reset; only the table and the allocation go.
  function void clear_slots();
    for (int i = 0; i < tps_pkg::TEXTURE_SLOTS_DEF; i++) begin
      slot_w[i]    = '0;
      slot_h[i]    = '0;
      slot_base[i] = 0;
      slot_live[i] = 1'b0;
    end
    texels_taken = 0;
  endfunction

  // Scale by the size, drop the fraction bits (floor), wrap with size-1.
  function int unsigned wrap_axis(logic signed [31:0] c, int unsigned size);
    longint p;
    p = longint'(c) * longint'(size);
    return int'((p >>> tps_pkg::UV_FRACTION_BITS_DEF) & longint'(size - 1));
  endfunction

  function int unsigned sample_addr(int s, logic signed [31:0] u, logic signed [31:0] v);
    int unsigned xu;
    int unsigned yv;
    xu = wrap_axis(u, int'(slot_w[s]));
    yv = wrap_axis(v, int'(slot_h[s]));
    return slot_base[s] + yv * int'(slot_w[s]) + xu;
  endfunction

  function void note_word(tex_word_t wd);
    tex_result_t r;
    int          s;
    int unsigned needed;
    int unsigned addr;
    r.status   = tps_pkg::ST_OK;
    r.slot_res = '0;
    r.texel    = '0;
    s = int'(wd.slot);
    if (wd.op == tps_pkg::OP_RESET) begin
      clear_slots();
    end else if (s >= tps_pkg::TEXTURE_SLOTS_DEF) begin
      r.status = tps_pkg::ST_BAD_SLOT;
    end else if (wd.op == tps_pkg::OP_CREATE) begin
      needed = int'(wd.w) * int'(wd.h);
      if (needed == 0 || needed > tps_pkg::POOL_TEXELS_DEF - texels_taken) begin
        r.status = tps_pkg::ST_NO_SPACE;
      end else begin
        slot_w[s]    = wd.w;
        slot_h[s]    = wd.h;
        slot_base[s] = texels_taken;
        slot_live[s] = 1'b1;
        texels_taken += needed;
        r.slot_res   = wd.slot;
      end
    end else if (!slot_live[s]) begin
      r.status = tps_pkg::ST_UNUSED;
    end else if (wd.op == tps_pkg::OP_SET) begin
      addr = slot_base[s] + int'(wd.y) * int'(slot_w[s]) + int'(wd.x);
      if (addr >= tps_pkg::POOL_TEXELS_DEF) begin
        r.status = tps_pkg::ST_OUTSIDE;
      end else begin
        texel_mem[addr]     = wd.color;
        texel_written[addr] = 1'b1;
      end
    end else begin
      addr = sample_addr(s, wd.u, wd.v);
      if (addr < tps_pkg::POOL_TEXELS_DEF) r.texel = texel_mem[addr];
    end
    r.used = 17'(texels_taken * 2);
    due_results.push_back(r);
  endfunction

  function void check_result(tex_result_t act);
    tex_result_t exp;
    if (due_results.size() == 0) begin
      $display("%0t: result with no word pending: status %0d texel %h used %0d",
               $time, act.status, act.texel, act.used);
      errors++;
      return;
    end
    exp = due_results.pop_front();
    if (act.status !== exp.status) begin
      $display("%0t: status expected %0d, actual %0d", $time, exp.status, act.status);
      errors++;
    end
    if (act.slot_res !== exp.slot_res) begin
      $display("%0t: slot_result expected %0d, actual %0d", $time, exp.slot_res, act.slot_res);
      errors++;
    end
    if (act.texel !== exp.texel) begin
      $display("%0t: texel_out expected %h, actual %h", $time, exp.texel, act.texel);
      errors++;
    end
    if (act.used !== exp.used) begin
      $display("%0t: used_bytes expected %0d, actual %0d", $time, exp.used, act.used);
      errors++;
    end
  endfunction

  function int pending();
    return due_results.size();
  endfunction
endclass

module tb_texture_pool_sampler;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 7;
  localparam int PHASE_WORDS = 150;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic        [1:0]  operation_i;
  logic        [7:0]  slot_index_i;
  logic        [7:0]  tex_width_i;
  logic        [7:0]  tex_height_i;
  logic        [7:0]  texel_x_i;
  logic        [7:0]  texel_y_i;
  logic        [15:0] color_in_i;
  logic signed [31:0] coord_u_i;
  logic signed [31:0] coord_v_i;
  logic               result_valid_o;
  logic        [2:0]  status_o;
  logic        [7:0]  slot_result_o;
  logic        [15:0] texel_out_o;
  logic        [16:0] used_bytes_o;

  tex_pool_tracker pool;
  int              gap_max;
  int              cycles = 0;

  texture_pool_sampler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .slot_index_i   (slot_index_i),
    .tex_width_i    (tex_width_i),
    .tex_height_i   (tex_height_i),
    .texel_x_i      (texel_x_i),
    .texel_y_i      (texel_y_i),
    .color_in_i     (color_in_i),
    .coord_u_i      (coord_u_i),
    .coord_v_i      (coord_v_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .slot_result_o  (slot_result_o),
    .texel_out_o    (texel_out_o),
    .used_bytes_o   (used_bytes_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    tex_result_t act;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      act.status   = status_o;
      act.slot_res = slot_result_o;
      act.texel    = texel_out_o;
      act.used     = used_bytes_o;
      pool.check_result(act);
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic drive_word(tex_word_t wd);
    int gap;
    gap = (gap_max > 0) ? $urandom_range(gap_max) : 0;
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i  = wd.op;
    slot_index_i = wd.slot;
    tex_width_i  = wd.w;
    tex_height_i = wd.h;
    texel_x_i    = wd.x;
    texel_y_i    = wd.y;
    color_in_i   = wd.color;
    coord_u_i    = wd.u;
    coord_v_i    = wd.v;
    start_i      = 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pool.note_word(wd);
    @(negedge clk_i);
  endtask

  // Never sample an unwritten texel: write the target first when needed.
  task automatic issue(tex_word_t wd);
    tex_word_t   fill;
    int          s;
    int unsigned addr;
    s = int'(wd.slot);
    if (wd.op == tps_pkg::OP_SAMPLE && s < tps_pkg::TEXTURE_SLOTS_DEF && pool.slot_live[s]) begin
      addr = pool.sample_addr(s, wd.u, wd.v);
      if (!pool.texel_written[addr]) begin
        fill       = wd;
        fill.op    = tps_pkg::OP_SET;
        fill.x     = 8'(pool.wrap_axis(wd.u, int'(pool.slot_w[s])));
        fill.y     = 8'(pool.wrap_axis(wd.v, int'(pool.slot_h[s])));
        fill.color = 16'($urandom);
        drive_word(fill);
      end
    end
    drive_word(wd);
  endtask

  task automatic directed(logic [1:0] op, logic [7:0] slot, logic [7:0] w, logic [7:0] h,
                          logic [7:0] x, logic [7:0] y, logic [15:0] color,
                          logic signed [31:0] u, logic signed [31:0] v);
    tex_word_t wd;
    wd = '{op: op, slot: slot, w: w, h: h, x: x, y: y, color: color, u: u, v: v};
    issue(wd);
  endtask

  task automatic drain();
    start_i = 1'b0;
    while (pool.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_slot();
    logic [7:0] s;
    if ($urandom_range(15) == 0) return 8'($urandom);
    for (int i = 0; i < 8; i++) begin
      s = 8'($urandom_range(tps_pkg::TEXTURE_SLOTS_DEF - 1));
      if (pool.slot_live[s]) return s;
    end
    return 8'($urandom_range(tps_pkg::TEXTURE_SLOTS_DEF - 1));
  endfunction

  function automatic tex_word_t random_word();
    tex_word_t wd;
    int        pick;
    int        sz;
    wd.op    = 2'($urandom);
    wd.slot  = 8'($urandom);
    wd.w     = 8'($urandom);
    wd.h     = 8'($urandom);
    wd.x     = 8'($urandom);
    wd.y     = 8'($urandom);
    wd.color = 16'($urandom);
    wd.u     = $urandom;
    wd.v     = $urandom;
    pick = $urandom_range(99);
    if (pick < 5) return wd;
    if (pick < 8) begin
      wd.op = tps_pkg::OP_RESET;
    end else if (pick < 20) begin
      wd.op   = tps_pkg::OP_CREATE;
      wd.slot = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15));
      sz = $urandom_range(9);
      if (sz < 7) begin
        wd.w = 8'($urandom_range(1, 8));
        wd.h = 8'($urandom_range(1, 8));
      end else if (sz == 7) begin
        wd.w = 8'd1 << $urandom_range(6);
        wd.h = 8'd1 << $urandom_range(6);
      end else if (sz == 8) begin
        wd.h = ($urandom_range(1) != 0) ? 8'd0 : wd.h;
        wd.w = (wd.h != 0) ? 8'd0 : wd.w;
      end
    end else if (pick < 58) begin
      wd.op   = tps_pkg::OP_SET;
      wd.slot = pick_slot();
      if (wd.slot < tps_pkg::TEXTURE_SLOTS_DEF && pool.slot_live[wd.slot] &&
          $urandom_range(9) != 0) begin
        wd.x = 8'($urandom_range(pool.slot_w[wd.slot] - 1));
        wd.y = 8'($urandom_range(pool.slot_h[wd.slot] - 1));
      end
    end else begin
      wd.op   = tps_pkg::OP_SAMPLE;
      wd.slot = pick_slot();
      if ($urandom_range(1) != 0) begin
        wd.u = int'($urandom_range(65535)) - 32768;
        wd.v = int'($urandom_range(65535)) - 32768;
      end
    end
    return wd;
  endfunction

  initial begin
    pool         = new();
    gap_max      = 3;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    operation_i  = tps_pkg::OP_RESET;
    slot_index_i = '0;
    tex_width_i  = '0;
    tex_height_i = '0;
    texel_x_i    = '0;
    texel_y_i    = '0;
    color_in_i   = '0;
    coord_u_i    = '0;
    coord_v_i    = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Unused, bad slot and zero size answers.
    directed(tps_pkg::OP_SAMPLE, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 0, 0);
    directed(tps_pkg::OP_SET,    8'd3,   8'd0,   8'd0,   8'd1,   8'd1,   16'h1111, 0, 0);
    directed(tps_pkg::OP_CREATE, 8'd200, 8'd4,   8'd4,   8'd0,   8'd0,   16'h0000, 0, 0);
    directed(tps_pkg::OP_SAMPLE, 8'd16,  8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 0, 0);
    directed(tps_pkg::OP_CREATE, 8'd0,   8'd0,   8'd5,   8'd0,   8'd0,   16'h0000, 0, 0);
    directed(tps_pkg::OP_CREATE, 8'd1,   8'd7,   8'd0,   8'd0,   8'd0,   16'h0000, 0, 0);
    // Fill the pool to the last texel, with one refusal on the way.
    directed(tps_pkg::OP_CREATE, 8'd0,   8'd4,   8'd4,   8'd0,   8'd0,   16'h0000, 0, 0);
    directed(tps_pkg::OP_CREATE, 8'd15,  8'd255, 8'd128, 8'd0,   8'd0,   16'h0000, 0, 0);
    directed(tps_pkg::OP_CREATE, 8'd1,   8'd16,  8'd16,  8'd0,   8'd0,   16'h0000, 0, 0);
    directed(tps_pkg::OP_CREATE, 8'd2,   8'd8,   8'd14,  8'd0,   8'd0,   16'h0000, 0, 0);
    // Writes: corner, column past the width, outside the pool, far corner.
    directed(tps_pkg::OP_SET,    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   16'hFFFF, 0, 0);
    directed(tps_pkg::OP_SET,    8'd0,   8'd0,   8'd0,   8'd5,   8'd1,   16'h1234, 0, 0);
    directed(tps_pkg::OP_SET,    8'd2,   8'd0,   8'd0,   8'd255, 8'd255, 16'hABCD, 0, 0);
    directed(tps_pkg::OP_SET,    8'd15,  8'd0,   8'd0,   8'd254, 8'd127, 16'h7FFF, 0, 0);
    // Samples at zero, just below zero and at the coordinate extremes.
    directed(tps_pkg::OP_SAMPLE, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 0, 0);
    directed(tps_pkg::OP_SAMPLE, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, -1, -1);
    directed(tps_pkg::OP_SAMPLE, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   16'h0000,
             32'sh7FFFFFFF, 32'sh80000000);
    directed(tps_pkg::OP_SAMPLE, 8'd15,  8'd0,   8'd0,   8'd0,   8'd0,   16'h0000,
             32'shFFFFF000, 32'sh00000FFF);
    // Pool reset keeps pixels; recreate over an in-use slot; odd sizes.
    directed(tps_pkg::OP_RESET,  8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 0, 0);
    directed(tps_pkg::OP_SAMPLE, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 0, 0);
    directed(tps_pkg::OP_CREATE, 8'd5,   8'd3,   8'd5,   8'd0,   8'd0,   16'h0000, 0, 0);
    directed(tps_pkg::OP_CREATE, 8'd5,   8'd2,   8'd2,   8'd0,   8'd0,   16'h0000, 0, 0);
    directed(tps_pkg::OP_SAMPLE, 8'd5,   8'd0,   8'd0,   8'd0,   8'd0,   16'h0000,
             32'sh00001800, 32'sh00000800);
    directed(tps_pkg::OP_CREATE, 8'd6,   8'd3,   8'd5,   8'd0,   8'd0,   16'h0000, 0, 0);
    directed(tps_pkg::OP_SAMPLE, 8'd6,   8'd0,   8'd0,   8'd0,   8'd0,   16'h0000,
             32'sh00000AAB, 32'sh00001234);

    for (int ph = 0; ph < PHASES; ph++) begin
      // Hold the sender until every result is back, then change the gap profile.
      drain();
      gap_max = (ph % 4 == 0) ? 0 : 3;
      for (int i = 0; i < PHASE_WORDS; i++) issue(random_word());
    end

    start_i = 1'b0;
    while (pool.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pool.errors == 0 && pool.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
